### design/rthp_pkg.sv
// rthp_pkg: shared types and constants of the rgb to hsv pixel pipeline
// no dependencies; used by the interfaces and every module of the block

package rthp_pkg;

  localparam int CH_W      = 8;                   // width of one colour channel
  localparam int NUM_W     = 16;                  // dividend width of both dividers
  localparam int DIV_STEPS = 8;                   // one quotient bit per step
  localparam int DSH_W     = CH_W + DIV_STEPS - 1; // divisor aligned to the top quotient bit

  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  localparam logic [CH_W-1:0] HUE_RED_OFS   = 8'd0;
  localparam logic [CH_W-1:0] HUE_GREEN_OFS = 8'd60;
  localparam logic [CH_W-1:0] HUE_BLUE_OFS  = 8'd120;
  localparam logic [CH_W-1:0] HUE_TURN      = 8'd180;
  localparam logic [CH_W-1:0] HUE_SCALE     = 8'd30;

  // first front stage: extremes and sector
  typedef struct packed {
    logic [CH_W-1:0]        bright;
    logic [CH_W-1:0]        diff;
    logic [1:0]             sector;
    logic signed [CH_W:0]   delta;
  } front_t;

  // state carried through the divider steps
  typedef struct packed {
    logic [NUM_W-1:0] hue_rem;
    logic [DSH_W-1:0] hue_dsh;
    logic [CH_W-1:0]  hue_q;
    logic [NUM_W-1:0] sat_rem;
    logic [DSH_W-1:0] sat_dsh;
    logic [CH_W-1:0]  sat_q;
    logic [CH_W-1:0]  bright;
    logic             gray;
  } div_t;

endpackage

### design/rthp_if.sv
// rthp_if: valid/ready channel interfaces for rgb input and hsv output pixels
// depends on rthp_pkg for the channel width

interface rthp_rgb_if;
  logic                       valid;
  logic                       ready;
  logic [rthp_pkg::CH_W-1:0]  red;
  logic [rthp_pkg::CH_W-1:0]  green;
  logic [rthp_pkg::CH_W-1:0]  blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface rthp_hsv_if;
  logic                       valid;
  logic                       ready;
  logic [rthp_pkg::CH_W-1:0]  hue;
  logic [rthp_pkg::CH_W-1:0]  saturation;
  logic [rthp_pkg::CH_W-1:0]  brightness;
  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

### design/rgb_to_hsv_pixel_unit.sv
// rgb_to_hsv_pixel_unit: top level of the 8-bit rgb to hsv converter
// depends on rthp_pkg, rthp_if, rthp_front and rthp_div_step
//
// rgb is a valid/ready sink carrying one pixel (red, green, blue) per
// transaction; hsv is a valid/ready source giving hue in half-degrees
// (0..179), saturation and brightness for each pixel, in input order.
// From the accepting edge to hsv.valid a pixel passes two front
// stages (extremes, dividends), eight divider steps that each resolve one
// quotient bit of both divisions, and the output register.
// Throughput is one pixel per cycle while hsv.ready stays high: every stage is a register with its own
// valid bit, and the eight-step divider chain sets the latency, not the rate.
// When the receiver holds hsv.ready low the result stays in the output
// register and stages behind it keep filling empty slots; rgb.ready drops
// only once every stage holds a pixel. Nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits; the pipeline is then empty
// and accepts a pixel in the next cycle.

module rgb_to_hsv_pixel_unit (
  input  logic        clk,
  input  logic        rst,
  rthp_rgb_if.sink    rgb,
  rthp_hsv_if.source  hsv
);

  rthp_pkg::div_t d   [0:rthp_pkg::DIV_STEPS];
  logic           dv  [0:rthp_pkg::DIV_STEPS];
  logic           dr  [0:rthp_pkg::DIV_STEPS];
  logic           out_ready_up;
  rthp_pkg::div_t last;

  rthp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rgb.valid),
    .in_ready  (rgb.ready),
    .red       (rgb.red),
    .green     (rgb.green),
    .blue      (rgb.blue),
    .out_valid (dv[0]),
    .out_ready (dr[0]),
    .out_data  (d[0])
  );

  for (genvar i = 0; i < rthp_pkg::DIV_STEPS; i++) begin : g_div
    rthp_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[i]),
      .in_ready  (dr[i]),
      .in_data   (d[i]),
      .out_valid (dv[i+1]),
      .out_ready (dr[i+1]),
      .out_data  (d[i+1])
    );
  end

  assign last         = d[rthp_pkg::DIV_STEPS];
  assign out_ready_up = !hsv.valid || hsv.ready;
  assign dr[rthp_pkg::DIV_STEPS] = out_ready_up;

  // output register, gray and black pixels force hue and saturation to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      hsv.valid <= 1'b0;
    end else if (out_ready_up) begin
      hsv.valid <= dv[rthp_pkg::DIV_STEPS];
    end
    if (out_ready_up && dv[rthp_pkg::DIV_STEPS]) begin
      hsv.hue        <= last.gray ? '0 : last.hue_q;
      hsv.saturation <= last.gray ? '0 : last.sat_q;
      hsv.brightness <= last.bright;
    end
  end

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv.valid |-> (hsv.hue < 8'd180))
    else $error("hue out of range");

  a_black_unsaturated: assert property (@(posedge clk) disable iff (rst)
    (hsv.valid && hsv.brightness == '0) |-> (hsv.saturation == '0))
    else $error("black pixel with nonzero saturation");

  a_gray_hue: assert property (@(posedge clk) disable iff (rst)
    (hsv.valid && hsv.saturation == '0) |-> (hsv.hue == '0))
    else $error("unsaturated pixel with nonzero hue");

  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    (!dv[rthp_pkg::DIV_STEPS] && hsv.valid && !hsv.ready)
      |=> (hsv.valid && !dv[rthp_pkg::DIV_STEPS] || hsv.valid))
    else $error("stalled result dropped");

endmodule

### design/rthp_front.sv
// rthp_front: two pipeline stages that find max, min and sector, then build
// the dividends and aligned divisors; depends on rthp_pkg

module rthp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rthp_pkg::CH_W-1:0] red,
  input  logic [rthp_pkg::CH_W-1:0] green,
  input  logic [rthp_pkg::CH_W-1:0] blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rthp_pkg::div_t            out_data
);

  rthp_pkg::front_t s1, s1_next;
  logic             s1_valid;
  logic             s1_ready;
  logic             s2_ready;
  rthp_pkg::div_t   s2_next;

  logic [rthp_pkg::CH_W-1:0]  mn;
  logic signed [17:0]         delta_x;
  logic signed [17:0]         delta30;
  logic [rthp_pkg::NUM_W-1:0] base;
  logic signed [17:0]         num_s;

  // stage one: extremes, ties resolved red over green over blue
  always_comb begin
    s1_next = '0;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    if (red >= green && red >= blue) begin
      s1_next.sector = rthp_pkg::SEC_RED;
      s1_next.bright = red;
      s1_next.delta  = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green >= blue) begin
      s1_next.sector = rthp_pkg::SEC_GREEN;
      s1_next.bright = green;
      s1_next.delta  = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      s1_next.sector = rthp_pkg::SEC_BLUE;
      s1_next.bright = blue;
      s1_next.delta  = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    s1_next.diff = s1_next.bright - mn;
  end

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1 <= s1_next;
    end
  end

  // stage two: hue and saturation dividends and aligned divisors, the red sector wraps by a full turn when negative
  assign delta_x = 18'(s1.delta);
  assign delta30 = delta_x * $signed({10'd0, rthp_pkg::HUE_SCALE});

  always_comb begin
    case (s1.sector)
      rthp_pkg::SEC_RED: begin
        if (s1.delta < 0) base = 16'(s1.diff) * 16'(rthp_pkg::HUE_TURN);
        else base = 16'(s1.diff) * 16'(rthp_pkg::HUE_RED_OFS);
      end
      rthp_pkg::SEC_GREEN: base = 16'(s1.diff) * 16'(rthp_pkg::HUE_GREEN_OFS);
      rthp_pkg::SEC_BLUE:  base = 16'(s1.diff) * 16'(rthp_pkg::HUE_BLUE_OFS);
      default:             base = '0;
    endcase
    num_s = $signed({2'b00, base}) + delta30;

    s2_next.hue_rem = num_s[rthp_pkg::NUM_W-1:0];
    s2_next.hue_dsh = {s1.diff, {(rthp_pkg::DIV_STEPS-1){1'b0}}};
    s2_next.hue_q   = '0;
    // 255 * diff
    s2_next.sat_rem = {s1.diff, 8'd0} - 16'(s1.diff);
    s2_next.sat_dsh = {s1.bright, {(rthp_pkg::DIV_STEPS-1){1'b0}}};
    s2_next.sat_q   = '0;
    s2_next.bright  = s1.bright;
    s2_next.gray    = (s1.diff == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      out_data <= s2_next;
    end
  end

endmodule

### design/rthp_div_step.sv
// rthp_div_step: one registered restoring-division step for both hue and
// saturation quotients, one quotient bit each; depends on rthp_pkg

module rthp_div_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rthp_pkg::div_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rthp_pkg::div_t out_data
);

  rthp_pkg::div_t step_next;
  logic           hue_ge;
  logic           sat_ge;

  always_comb begin
    step_next = in_data;
    hue_ge = in_data.hue_rem >= {1'b0, in_data.hue_dsh};
    sat_ge = in_data.sat_rem >= {1'b0, in_data.sat_dsh};
    if (hue_ge) step_next.hue_rem = in_data.hue_rem - {1'b0, in_data.hue_dsh};
    if (sat_ge) step_next.sat_rem = in_data.sat_rem - {1'b0, in_data.sat_dsh};
    step_next.hue_q   = {in_data.hue_q[rthp_pkg::CH_W-2:0], hue_ge};
    step_next.sat_q   = {in_data.sat_q[rthp_pkg::CH_W-2:0], sat_ge};
    step_next.hue_dsh = in_data.hue_dsh >> 1;
    step_next.sat_dsh = in_data.sat_dsh >> 1;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= step_next;
    end
  end

endmodule
